/* design/asae_pkg.sv */
// Shared types, constants and the armoring function for the AIS six-bit
// armor encoder. No dependencies.
package asae_pkg;

   // Bits per armored group and the armoring split point
   localparam int unsigned GROUP_BITS = 6;
   localparam logic [5:0] ARMOR_SPLIT = 6'd40;
   localparam logic [6:0] ARMOR_LOW_OFFSET = 7'd48;
   localparam logic [6:0] ARMOR_HIGH_OFFSET = 7'd56;

   // One job handed from the front to the back: one or two groups of a byte
   typedef struct packed {
      logic [5:0] group0;
      logic [5:0] group1;
      logic       two;
      logic       last;
   } job_type;

   // Map a 6-bit group onto its armored ASCII character
   function automatic logic [6:0] armor(input logic [5:0] group);
      logic [6:0] offset;
      offset = (group < ARMOR_SPLIT) ? ARMOR_LOW_OFFSET : ARMOR_HIGH_OFFSET;
      return {1'b0, group} + offset;
   endfunction

endpackage

/* design/asae_front.sv */
// Front end of the armor encoder: takes request bytes, merges them with the
// leftover bits and classifies them into jobs of up to two groups.
// Depends on asae_pkg.
module asae_front (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        req_data_byte,
   input  logic [3:0]        req_valid_bits,
   input  logic              req_is_last,
   input  logic              accept,
   output logic              job_push,
   output asae_pkg::job_type job
);

   logic [3:0]  pending_bits_ff;
   logic [3:0]  pending_bits_in;
   logic [2:0]  pending_count_ff;
   logic [2:0]  pending_count_in;

   logic [3:0]  take;
   logic [3:0]  shift_amt;
   logic [11:0] acc;
   logic [3:0]  total;
   logic [3:0]  above_group;
   logic [11:0] high_part;
   logic [1:0]  full_groups;
   logic [2:0]  rest;
   logic [5:0]  rest_mask;
   logic [5:0]  rest_bits;
   logic [5:0]  padded;
   logic        pad;

   // Merge leftover bits with the leading bits of this byte
   always_comb begin
      if (!req_is_last) begin
         take = 4'd8;
      end else if (req_valid_bits > 4'd8) begin
         take = 4'd8;
      end else begin
         take = req_valid_bits;
      end
      shift_amt   = 4'd8 - take;
      acc         = {pending_bits_ff, req_data_byte} >> shift_amt;
      total       = {1'b0, pending_count_ff} + take;
      above_group = total - 4'd6;
   end

   // Split the merged bits into full groups and a remainder
   always_comb begin
      if (total >= 4'd12) begin
         full_groups = 2'd2;
         rest        = 3'd0;
      end else if (total >= 4'd6) begin
         full_groups = 2'd1;
         rest        = above_group[2:0];
      end else begin
         full_groups = 2'd0;
         rest        = total[2:0];
      end
      high_part = acc >> above_group;
      rest_mask = (6'd1 << rest) - 6'd1;
      rest_bits = acc[5:0] & rest_mask;
      padded    = rest_bits << (3'd6 - rest);
      pad       = req_is_last && (rest != 3'd0);
   end

   // Build the job record for the back end
   always_comb begin
      job.last = req_is_last;
      case (full_groups)
         2'd2: begin
            job.group0 = high_part[5:0];
            job.group1 = acc[5:0];
            job.two    = 1'b1;
         end
         2'd1: begin
            job.group0 = high_part[5:0];
            job.group1 = padded;
            job.two    = pad;
         end
         default: begin
            job.group0 = padded;
            job.group1 = padded;
            job.two    = 1'b0;
         end
      endcase
      job_push = accept && ((full_groups != 2'd0) || pad);
   end

   // Keep the leftover bits; clear them at the end of a message
   always_comb begin
      pending_bits_in  = pending_bits_ff;
      pending_count_in = pending_count_ff;
      if (accept) begin
         if (req_is_last) begin
            pending_bits_in  = 4'd0;
            pending_count_in = 3'd0;
         end else begin
            pending_bits_in  = rest_bits[3:0];
            pending_count_in = rest;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_bits_ff  <= 4'd0;
         pending_count_ff <= 3'd0;
      end else begin
         pending_bits_ff  <= pending_bits_in;
         pending_count_ff <= pending_count_in;
      end
   end

   // Leftover is always an even count of at most four bits
   a_pending_count: assert property (@(posedge clock) disable iff (reset)
      (pending_count_ff == 3'd0) || (pending_count_ff == 3'd2) ||
      (pending_count_ff == 3'd4))
      else $error("leftover bit count out of range");

   // Bits above the leftover count stay clear
   a_pending_clean: assert property (@(posedge clock) disable iff (reset)
      (pending_bits_ff >> pending_count_ff) == 4'd0)
      else $error("stale bits above leftover count");

endmodule

/* design/asae_job_queue.sv */
// Short job queue between the front and back of the armor encoder.
// Depends on asae_pkg.
module asae_job_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  asae_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output asae_pkg::job_type head_job
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   asae_pkg::job_type entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming job
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("job pushed into a full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("job queue occupancy beyond depth");

endmodule

/* design/asae_back.sv */
// Back end of the armor encoder: serialises each job's groups into armored
// characters through the response output register. Depends on asae_pkg.
module asae_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  asae_pkg::job_type head_job,
   output logic              job_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [6:0]        rsp_armored_char,
   output logic              rsp_last_char
);

   logic       out_valid_ff;
   logic       out_valid_in;
   logic [6:0] char_ff;
   logic [6:0] char_in;
   logic       last_ff;
   logic       last_in;
   logic       idx_ff;
   logic       idx_in;

   logic       load;
   logic       final_of_job;
   logic [5:0] group;

   // Pick the next group of the head job and load the output register
   always_comb begin
      load         = head_valid && (!out_valid_ff || rsp_pop);
      final_of_job = !head_job.two || idx_ff;
      group        = idx_ff ? head_job.group1 : head_job.group0;
      job_pop      = load && final_of_job;

      out_valid_in = out_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      idx_in       = idx_ff;
      if (load) begin
         out_valid_in = 1'b1;
         char_in      = asae_pkg::armor(group);
         last_in      = head_job.last && final_of_job;
         idx_in       = !final_of_job;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         idx_ff       <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   // Hold the character payload
   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_armored_char = char_ff;
   assign rsp_last_char    = last_ff;

   // Second group is only pending on a two-group job still at the head
   a_idx_head: assert property (@(posedge clock) disable iff (reset)
      idx_ff |-> head_valid && head_job.two)
      else $error("second group pending without a two-group head job");

endmodule

/* design/ais_sixbit_armor_encoder_unit.sv */
// AIS six-bit armor encoder: regroups a byte stream (MSB first) into 6-bit
// groups and emits each as an armored ASCII character, flagging the last.
// Depends on asae_pkg, asae_front, asae_job_queue and asae_back.
//
// A byte is taken in the cycle it is pushed; when the block is idle its first
// character passes through the job queue and the response output register to
// reach the rsp_ ports. The front end accepts one byte per cycle while the job
// queue has room; the back end delivers one character per cycle from its output
// register while pop keeps it drained, so a byte that yields two characters
// holds its job at the queue head until both are loaded. Sustained intake is one
// byte per cycle for bytes yielding at most one character; over a steady run of
// full bytes (four characters per three bytes) the back-end serialiser sets it.
// JOB_DEPTH sets how many byte jobs may wait between front and back.
module ais_sixbit_armor_encoder_unit #(
   parameter int unsigned JOB_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_data_byte,
   input  logic [3:0] req_valid_bits,
   input  logic       req_is_last,
   output logic       empty,
   input  logic       pop,
   output logic [6:0] rsp_armored_char,
   output logic       rsp_last_char
);

   logic              accept;
   logic              job_push;
   asae_pkg::job_type push_job;
   logic              job_pop;
   logic              head_valid;
   asae_pkg::job_type head_job;

   assign accept = push && !full;

   asae_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_data_byte  (req_data_byte),
      .req_valid_bits (req_valid_bits),
      .req_is_last    (req_is_last),
      .accept         (accept),
      .job_push       (job_push),
      .job            (push_job)
   );

   asae_job_queue #(
      .DEPTH (JOB_DEPTH)
   ) u_job_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (push_job),
      .full       (full),
      .pop        (job_pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   asae_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_job         (head_job),
      .job_pop          (job_pop),
      .rsp_empty        (empty),
      .rsp_pop          (pop),
      .rsp_armored_char (rsp_armored_char),
      .rsp_last_char    (rsp_last_char)
   );

endmodule
